### src/pp_pkg.sv
// Shared types and constants for the polygon perimeter block.
`default_nettype none

package pp_pkg;

  localparam int COORD_W = 16;  // vertex coordinate width
  localparam int MAG_W   = 16;  // |dx|, |dy| width
  localparam int SQ_W    = 33;  // dx*dx + dy*dy width
  localparam int RAD_W   = 50;  // radicand (sq << 16), padded to an even width
  localparam int ROOT_W  = 25;  // edge length, Q.8
  localparam int REM_W   = 27;  // root remainder
  localparam int SUM_W   = 29;  // perimeter, Q21.8
  localparam int CNT_W   = 5;   // vertex count

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
  localparam logic [CNT_W-1:0] CNT_MIN = 5'd3;
  localparam logic [SUM_W-1:0] SUM_MAX = 29'h1FFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_DONE
  } state_t;

  // |a - b| of two signed coordinates; always fits in 16 unsigned bits.
  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 17'd1) : d;
    return m[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/polygon_perimeter.sv
// Top level: Euclidean polygon perimeter, one vertex per input transfer.
//
// Input channel (in_valid/in_ready): one vertex per transfer, signed x and y,
// in_last_vertex marks the vertex that closes the polygon. Result channel
// (out_valid/out_ready): one transfer per closed polygon with the Q21.8
// perimeter (saturating), the vertex total (saturating at 31) and a flag set
// when the total is below 3 or above MAX_VERTICES.
// Each edge goes through a bit-serial squarer (|dx|^2 + |dy|^2) and a
// digit-serial square root (one root bit per cycle) before the sum update.
// The first vertex of a polygon is only stored; each further vertex adds its
// edge to the previous vertex before the next transfer is taken; the last
// vertex adds its own edge and then the closing edge to the first vertex,
// after which the result register is loaded. A lone closing vertex goes
// straight to the result register.
// One vertex is processed at a time.
// The result sits in an output register: the block goes back to taking
// vertices while it waits; it only stalls when a second result is ready
// before the first was taken.
// Reset (rst_n low, synchronous) clears the polygon state and drops
// out_valid. After each result the polygon state is cleared again.
`default_nettype none

module polygon_perimeter #(
  parameter int MAX_VERTICES = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [pp_pkg::COORD_W-1:0]   in_x,
  input  wire logic [pp_pkg::COORD_W-1:0]   in_y,
  input  wire logic                         in_last_vertex,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [pp_pkg::SUM_W-1:0]          out_perimeter,
  output logic [pp_pkg::CNT_W-1:0]          out_vertex_total,
  output logic                              out_count_error
);

  localparam logic [pp_pkg::CNT_W-1:0] MAX_CNT = pp_pkg::CNT_W'(MAX_VERTICES);

  pp_pkg::state_t state_r, state_nxt;

  // Polygon state
  logic [pp_pkg::COORD_W-1:0] first_x_r, first_y_r;
  logic [pp_pkg::COORD_W-1:0] prev_x_r, prev_y_r;
  logic [pp_pkg::COORD_W-1:0] cur_x_r, cur_y_r;
  logic [pp_pkg::CNT_W-1:0]   seen_r;
  logic [pp_pkg::SUM_W-1:0]   sum_r;
  logic                       last_r;
  logic                       close_r;

  // Output register
  logic                       out_valid_r;
  logic [pp_pkg::SUM_W-1:0]   out_perim_r;
  logic [pp_pkg::CNT_W-1:0]   out_total_r;
  logic                       out_err_r;

  // Control strobes
  logic accept, sq_start, rt_start, sum_add, close_go, out_load;
  logic [pp_pkg::MAG_W-1:0] sq_ux, sq_uy;

  // Serial units
  logic                      sq_done, rt_done;
  logic [pp_pkg::SQ_W-1:0]   sq_val;
  logic [pp_pkg::ROOT_W-1:0] root_val;
  logic [pp_pkg::SUM_W:0]    sum_wide;
  logic [pp_pkg::SUM_W-1:0]  sum_sat;

  pp_sqr u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .ux    (sq_ux),
    .uy    (sq_uy),
    .done  (sq_done),
    .sq    (sq_val)
  );

  pp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .sq    (sq_val),
    .done  (rt_done),
    .root  (root_val)
  );

  assign sum_wide = {1'b0, sum_r} + {{(pp_pkg::SUM_W+1-pp_pkg::ROOT_W){1'b0}}, root_val};
  assign sum_sat  = sum_wide[pp_pkg::SUM_W] ? pp_pkg::SUM_MAX : sum_wide[pp_pkg::SUM_W-1:0];

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    sq_start  = 1'b0;
    rt_start  = 1'b0;
    sum_add   = 1'b0;
    close_go  = 1'b0;
    out_load  = 1'b0;
    // edge from new vertex to previous one, or closing edge to the first
    sq_ux     = close_r ? pp_pkg::abs_diff(cur_x_r, first_x_r)
                        : pp_pkg::abs_diff(in_x, prev_x_r);
    sq_uy     = close_r ? pp_pkg::abs_diff(cur_y_r, first_y_r)
                        : pp_pkg::abs_diff(in_y, prev_y_r);
    case (state_r)
      pp_pkg::ST_IDLE: begin
        if (in_valid) begin
          accept = 1'b1;
          if (seen_r != '0) begin
            sq_start  = 1'b1;
            state_nxt = pp_pkg::ST_SQR;
          end else if (in_last_vertex) begin
            // single-vertex polygon: closing edge has zero length
            state_nxt = pp_pkg::ST_DONE;
          end
        end
      end
      pp_pkg::ST_SQR: begin
        if (sq_done) begin
          rt_start  = 1'b1;
          state_nxt = pp_pkg::ST_ROOT;
        end
      end
      pp_pkg::ST_ROOT: begin
        if (rt_done) begin
          sum_add = 1'b1;
          if (close_r) begin
            close_go  = 1'b1;
            sq_start  = 1'b1;
            state_nxt = pp_pkg::ST_SQR;
          end else if (last_r) begin
            state_nxt = pp_pkg::ST_DONE;
          end else begin
            state_nxt = pp_pkg::ST_IDLE;
          end
        end
      end
      pp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = pp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Polygon state; cleared at reset and after each result
  always_ff @(posedge clk) begin
    if (!rst_n || out_load) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      seen_r    <= '0;
      sum_r     <= '0;
      last_r    <= 1'b0;
      close_r   <= 1'b0;
    end else begin
      if (accept) begin
        if (seen_r == '0) begin
          first_x_r <= in_x;
          first_y_r <= in_y;
        end
        prev_x_r <= in_x;
        prev_y_r <= in_y;
        if (seen_r != pp_pkg::CNT_MAX) seen_r <= seen_r + 5'd1;
        last_r  <= in_last_vertex;
        // closing edge pending only when an own edge goes first
        close_r <= in_last_vertex && (seen_r != '0);
      end
      if (sum_add) sum_r <= sum_sat;
      if (close_go) close_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= in_x;
      cur_y_r <= in_y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_perim_r <= sum_r;
      out_total_r <= seen_r;
      out_err_r   <= (seen_r < pp_pkg::CNT_MIN) || (seen_r > MAX_CNT);
    end
  end

  assign in_ready         = (state_r == pp_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_perimeter    = out_perim_r;
  assign out_vertex_total = out_total_r;
  assign out_count_error  = out_err_r;

endmodule

`default_nettype wire

### src/pp_sqr.sv
// Bit-serial sum of squares: ux*ux + uy*uy, one multiplier bit per cycle.
`default_nettype none

module pp_sqr (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pp_pkg::MAG_W-1:0]  ux,
  input  wire logic [pp_pkg::MAG_W-1:0]  uy,
  output logic                           done,
  output logic [pp_pkg::SQ_W-1:0]        sq
);

  logic                       busy_r;
  logic                       done_r;
  logic [3:0]                 cnt_r;
  logic [pp_pkg::MAG_W-1:0]   ax_r;
  logic [pp_pkg::MAG_W-1:0]   ay_r;
  logic [pp_pkg::SQ_W-1:0]    bx_r;
  logic [pp_pkg::SQ_W-1:0]    by_r;
  logic [pp_pkg::SQ_W-1:0]    acc_r;
  logic [pp_pkg::SQ_W-1:0]    acc_nxt;

  assign acc_nxt = acc_r + (ax_r[0] ? bx_r : '0) + (ay_r[0] ? by_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 4'd15);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax_r  <= ux;
      ay_r  <= uy;
      bx_r  <= {{(pp_pkg::SQ_W-pp_pkg::MAG_W){1'b0}}, ux};
      by_r  <= {{(pp_pkg::SQ_W-pp_pkg::MAG_W){1'b0}}, uy};
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      ax_r  <= ax_r >> 1;
      ay_r  <= ay_r >> 1;
      bx_r  <= bx_r << 1;
      by_r  <= by_r << 1;
    end
  end

  assign done = done_r;
  assign sq   = acc_r;

endmodule

`default_nettype wire

### src/pp_sqrt.sv
// Digit-by-digit floor square root of (sq << 16), one root bit per cycle.
`default_nettype none

module pp_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pp_pkg::SQ_W-1:0]   sq,
  output logic                           done,
  output logic [pp_pkg::ROOT_W-1:0]      root
);

  logic                        busy_r;
  logic                        done_r;
  logic [4:0]                  cnt_r;
  logic [pp_pkg::RAD_W-1:0]    rad_r;
  logic [pp_pkg::REM_W-1:0]    rem_r;
  logic [pp_pkg::ROOT_W-1:0]   q_r;
  logic [pp_pkg::REM_W+1:0]    rem_sh;
  logic [pp_pkg::REM_W+1:0]    trial;
  logic [pp_pkg::REM_W+1:0]    diff;
  logic                        ge;

  assign rem_sh = {rem_r, rad_r[pp_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, q_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd24);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd24) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= {1'b0, sq, 16'h0000};
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      rem_r <= diff[pp_pkg::REM_W-1:0];
      q_r   <= {q_r[pp_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = q_r;

endmodule

`default_nettype wire
